// ----- rtl/core/lph_pkg.sv -----
// Shared types and constants of the linear probing hash table.
package lph_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_REWIND = 3'd3;
    localparam logic [2:0] REQ_NEXT   = 3'd4;

    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_FOUND = 2'd1;
    localparam logic [1:0] RES_FULL  = 2'd2;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    // The FNV prime is 2^40 + 0x1B3.
    localparam int          FNV_SHIFT = 40;
    localparam logic [8:0]  FNV_LOW   = 9'h1B3;

    typedef struct packed {
        logic [2:0]  req;
        logic [63:0] key;
        logic [63:0] value;
        logic [63:0] hash;
    } cmd_t;

    function automatic logic [63:0] key_mask(input logic [3:0] nb);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < nb) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/lph_front.sv -----
// Front end: accepts commands, masks the key and, for insert, lookup and remove, hashes it one byte a cycle.
module lph_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         req_type,
    input  logic [63:0]        key,
    input  logic [63:0]        value,
    input  logic [3:0]         eff_bytes,
    input  logic [63:0]        mask,
    input  logic               clearing,
    input  logic               fifo_full,
    output logic               busy,
    output logic               push,
    output lph_pkg::cmd_t      push_cmd
);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

    fstate_t     state_reg;
    logic [2:0]  req_reg;
    logic [63:0] key_reg;
    logic [63:0] value_reg;
    logic [63:0] h_reg;
    logic [63:0] sh_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] h_x;
    logic [63:0] h_next;

    assign busy = (state_reg != F_IDLE) || clearing;
    assign push = (state_reg == F_PUSH) && !fifo_full;
    assign push_cmd = '{req: req_reg, key: key_reg, value: value_reg, hash: h_reg};

    assign h_x    = h_reg ^ {56'd0, sh_reg[7:0]};
    assign h_next = (h_x << lph_pkg::FNV_SHIFT) + (h_x * 64'(lph_pkg::FNV_LOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (start && !busy)
                    begin
                        req_reg   <= req_type;
                        key_reg   <= key & mask;
                        value_reg <= value;
                        h_reg     <= lph_pkg::FNV_BASIS;
                        sh_reg    <= key & mask;
                        cnt_reg   <= eff_bytes;
                        state_reg <= (req_type <= lph_pkg::REQ_REMOVE) ? F_HASH : F_PUSH;
                    end
                end
                F_HASH:
                begin
                    h_reg   <= h_next;
                    sh_reg  <= sh_reg >> 8;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!fifo_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/lph_fifo.sv -----
// Two-entry command queue between front end and back end.
module lph_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lph_pkg::cmd_t push_cmd,
    input  logic          pop,
    output lph_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    lph_pkg::cmd_t mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign head  = mem_reg[rd_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/core/lph_back.sv -----
// Back end: clears the status store after reset, probes the slot stores, updates them and registers the result.
module lph_back #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lph_pkg::cmd_t head,
    input  logic          empty,
    input  logic [63:0]   mask,
    output logic          pop,
    output logic          clearing,
    output logic          done,
    output logic [1:0]    status,
    output logic [63:0]   data_out,
    output logic [63:0]   key_out,
    output logic [8:0]    entry_total
);

    localparam int IW       = $clog2(SLOTS);
    localparam int CW       = $clog2(SLOTS + 1);
    localparam int FULL_LIM = (SLOTS * 3) / 4;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_WAIT, B_CHK, B_SWAIT, B_SCHK} bstate_t;

    logic [1:0]            status_mem [SLOTS];
    logic [63:0]           key_mem    [SLOTS];
    logic [VALUE_BITS-1:0] value_mem  [SLOTS];

    bstate_t               state_reg;
    lph_pkg::cmd_t         cmd_reg;
    logic [IW-1:0]         addr_reg;
    logic [IW-1:0]         clr_reg;
    logic [CW-1:0]         probe_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         cursor_reg;
    logic                  tomb_valid_reg;
    logic [IW-1:0]         tomb_idx_reg;
    logic [1:0]            st_q;
    logic [63:0]           key_q;
    logic [VALUE_BITS-1:0] val_q;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [63:0]           data_reg;
    logic [63:0]           kout_reg;

    logic                  hit;
    logic                  is_empty;
    logic                  last;
    logic                  probe_end;
    logic                  free_valid;
    logic [IW-1:0]         free_idx;
    logic                  table_full;
    logic                  ins_new;
    logic                  st_we;
    logic                  key_we;
    logic                  val_we;
    logic [IW-1:0]         w_addr;
    logic [1:0]            w_status;

    assign clearing    = (state_reg == B_CLEAR);
    assign pop         = (state_reg == B_IDLE) && !empty;
    assign done        = done_reg;
    assign status      = status_reg;
    assign data_out    = data_reg;
    assign key_out     = kout_reg;
    assign entry_total = 9'(count_reg);

    always_comb
    begin
        hit        = (st_q == lph_pkg::SLOT_USED) && ((key_q & mask) == cmd_reg.key);
        is_empty   = (st_q == lph_pkg::SLOT_EMPTY);
        last       = (probe_reg == CW'(SLOTS - 1));
        probe_end  = hit || is_empty || last;
        free_idx   = tomb_valid_reg ? tomb_idx_reg : addr_reg;
        free_valid = is_empty || tomb_valid_reg || (st_q == lph_pkg::SLOT_TOMB);
        table_full = (count_reg >= CW'(FULL_LIM));
        ins_new    = (cmd_reg.req == lph_pkg::REQ_INSERT) && !hit && !table_full
                     && free_valid;
        st_we    = 1'b0;
        key_we   = 1'b0;
        val_we   = 1'b0;
        w_addr   = addr_reg;
        w_status = lph_pkg::SLOT_USED;
        if (state_reg == B_CLEAR)
        begin
            st_we    = 1'b1;
            w_addr   = clr_reg;
            w_status = lph_pkg::SLOT_EMPTY;
        end
        else if (state_reg == B_CHK && probe_end)
        begin
            if (cmd_reg.req == lph_pkg::REQ_INSERT && hit)
            begin
                val_we = 1'b1;
            end
            else if (ins_new)
            begin
                st_we  = 1'b1;
                key_we = 1'b1;
                val_we = 1'b1;
                w_addr = free_idx;
            end
            else if (cmd_reg.req == lph_pkg::REQ_REMOVE && hit)
            begin
                st_we    = 1'b1;
                w_status = lph_pkg::SLOT_TOMB;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[w_addr] <= w_status;
        end
        if (key_we)
        begin
            key_mem[w_addr] <= cmd_reg.key;
        end
        if (val_we)
        begin
            value_mem[w_addr] <= cmd_reg.value[VALUE_BITS-1:0];
        end
        st_q  <= status_mem[addr_reg];
        key_q <= key_mem[addr_reg];
        val_q <= value_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            clr_reg    <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IW'(SLOTS - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        cmd_reg    <= head;
                        status_reg <= lph_pkg::RES_NONE;
                        data_reg   <= '0;
                        kout_reg   <= '0;
                        unique case (head.req)
                            lph_pkg::REQ_INSERT, lph_pkg::REQ_LOOKUP, lph_pkg::REQ_REMOVE:
                            begin
                                addr_reg       <= head.hash[IW-1:0];
                                probe_reg      <= '0;
                                tomb_valid_reg <= 1'b0;
                                state_reg      <= B_WAIT;
                            end
                            lph_pkg::REQ_REWIND:
                            begin
                                cursor_reg <= '0;
                                done_reg   <= 1'b1;
                            end
                            lph_pkg::REQ_NEXT:
                            begin
                                if (cursor_reg >= CW'(SLOTS))
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    addr_reg   <= cursor_reg[IW-1:0];
                                    cursor_reg <= cursor_reg + 1'b1;
                                    state_reg  <= B_SWAIT;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                B_WAIT:
                begin
                    state_reg <= B_CHK;
                end
                B_CHK:
                begin
                    if (probe_end)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                        if (hit)
                        begin
                            status_reg <= lph_pkg::RES_FOUND;
                            data_reg   <= 64'(val_q);
                            if (cmd_reg.req == lph_pkg::REQ_REMOVE)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        else if (ins_new)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else if (cmd_reg.req == lph_pkg::REQ_INSERT)
                        begin
                            status_reg <= lph_pkg::RES_FULL;
                        end
                    end
                    else
                    begin
                        if (st_q == lph_pkg::SLOT_TOMB && !tomb_valid_reg)
                        begin
                            tomb_valid_reg <= 1'b1;
                            tomb_idx_reg   <= addr_reg;
                        end
                        addr_reg  <= addr_reg + 1'b1;
                        probe_reg <= probe_reg + 1'b1;
                        state_reg <= B_WAIT;
                    end
                end
                B_SWAIT:
                begin
                    state_reg <= B_SCHK;
                end
                B_SCHK:
                begin
                    if (st_q == lph_pkg::SLOT_USED)
                    begin
                        status_reg <= lph_pkg::RES_FOUND;
                        data_reg   <= 64'(val_q);
                        kout_reg   <= key_q;
                        done_reg   <= 1'b1;
                        state_reg  <= B_IDLE;
                    end
                    else if (cursor_reg >= CW'(SLOTS))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        addr_reg   <= cursor_reg[IW-1:0];
                        cursor_reg <= cursor_reg + 1'b1;
                        state_reg  <= B_SWAIT;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/linear_probe_hash_table_core.sv -----
// Top level of the linear probing hash table: front end, command queue, back end.
//
// Channel   Direction  Handshake                     Payload
// command   in         start and not busy            req_type, key, value
// result    out        done, one cycle, no stall     status, data_out, key_out, entry_total
// config    in         cfg_valid and cfg_ready       cfg_data (key_bytes)
//
// After taking a command the front end hashes the key byte by byte (eff_bytes of them,
// key_bytes clamped to one through eight, for insert, lookup and remove, none for the
// other codes) and then pushes it into a two-entry queue, waiting while the queue is
// full; busy stays high until that push, so the next transaction can be taken once the
// queue has room. The back end pops the command and probes slot by slot, each slot read
// going through a registered memory port (B_WAIT, then B_CHK); a scan visits its slots
// through B_SWAIT and B_SCHK. After reset the back end clears the status store, one slot
// a cycle, and busy stays high until that pass ends. Results cannot be stalled: done is
// high for exactly one cycle per transaction.
module linear_probe_hash_table_core #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        done,
    output logic [1:0]  status,
    output logic [63:0] data_out,
    output logic [63:0] key_out,
    output logic [8:0]  entry_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic [3:0]    key_bytes_reg;
    logic [3:0]    eff_bytes;
    logic [63:0]   mask;
    logic          clearing;
    logic          fifo_full;
    logic          fifo_empty;
    logic          push;
    logic          pop;
    lph_pkg::cmd_t push_cmd;
    lph_pkg::cmd_t head;

    // The key width register is always writable; software must write it only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg <= 4'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_bytes_reg <= cfg_data;
        end
    end

    // A width of zero hashes one byte, anything above eight hashes eight.
    always_comb
    begin
        priority if (key_bytes_reg == 4'd0)
        begin
            eff_bytes = 4'd1;
        end
        else if (key_bytes_reg > 4'd8)
        begin
            eff_bytes = 4'd8;
        end
        else
        begin
            eff_bytes = key_bytes_reg;
        end
    end

    assign mask = lph_pkg::key_mask(eff_bytes);

    lph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .key       (key),
        .value     (value),
        .eff_bytes (eff_bytes),
        .mask      (mask),
        .clearing  (clearing),
        .fifo_full (fifo_full),
        .busy      (busy),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lph_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    lph_back #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (fifo_empty),
        .mask        (mask),
        .pop         (pop),
        .clearing    (clearing),
        .done        (done),
        .status      (status),
        .data_out    (data_out),
        .key_out     (key_out),
        .entry_total (entry_total)
    );

endmodule

// ----- rtl/core/lph_checker.sv -----
// Port-level checks of the hash table core and the bind that attaches them.
module lph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [1:0]  status,
    input logic [63:0] data_out,
    input logic [63:0] key_out,
    input logic [8:0]  entry_total
);

    // The entry count only moves at the edge that also raises done.
    a_total_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(entry_total))
        else $error("entry total changed without a result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == lph_pkg::RES_NONE || status == lph_pkg::RES_FOUND
                  || status == lph_pkg::RES_FULL))
        else $error("undefined status code");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == lph_pkg::RES_FULL) |-> (data_out == 64'd0 && key_out == 64'd0))
        else $error("refused insert returned data");

    a_none_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == lph_pkg::RES_NONE) |-> (key_out == 64'd0 && data_out == 64'd0))
        else $error("empty result carries data");

endmodule

bind linear_probe_hash_table_core lph_checker u_lph_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .status      (status),
    .data_out    (data_out),
    .key_out     (key_out),
    .entry_total (entry_total)
);

// ----- verif/tb_linear_probe_hash_table_core.sv -----
// Testbench for linear_probe_hash_table_core: random and directed traffic against a mirror table.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;

    localparam int SLOTS      = 256;
    localparam int VALUE_BITS = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

    // One command transaction as the driver sends it.
    typedef struct {
        logic [2:0]  req;
        logic [63:0] key;
        logic [63:0] value;
    } table_cmd_t;

    // One result transaction as the block should report it.
    typedef struct {
        logic [1:0]  status;
        logic [63:0] data;
        logic [63:0] key;
        logic [8:0]  total;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  req_type = '0;
    logic [63:0] key = '0;
    logic [63:0] value = '0;
    logic        done;
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [63:0] key_out;
    logic [8:0]  entry_total;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    // Commands waiting to be sent, and replies waiting to be seen.
    table_cmd_t   cmd_backlog[$];
    table_reply_t reply_queue[$];
    table_cmd_t   cmd_on_bus;
    bit           gaps_enabled = 1'b1;
    int           error_count = 0;
    int           cycle_count = 0;

    // Mirror of the table contents and the key width register.
    logic [1:0]  mirror_status[SLOTS];
    logic [63:0] mirror_key[SLOTS];
    logic [63:0] mirror_value[SLOTS];
    int          mirror_count;
    int          mirror_cursor;
    logic [3:0]  mirror_key_bytes;

    // Pool of keys per phase, so that many commands hit stored entries.
    logic [63:0] key_pool[64];

    linear_probe_hash_table_core #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .data_out    (data_out),
        .key_out     (key_out),
        .entry_total (entry_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Width 0 behaves as one byte and anything above 8 as eight bytes.
    function automatic int hashed_bytes();
        if (mirror_key_bytes == 4'd0) return 1;
        if (mirror_key_bytes > 4'd8) return 8;
        return int'(mirror_key_bytes);
    endfunction

    function automatic logic [63:0] bytes_mask(int nb);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < nb; i++) m[i*8 +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic logic [63:0] fnv1a(logic [63:0] k, int nb);
        logic [63:0] h;
        h = lph_pkg::FNV_BASIS;
        for (int i = 0; i < nb; i++) begin
            h = h ^ {56'd0, k[i*8 +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // Walks forward from the home slot. Returns the slot holding k or -1; on a miss free_slot
    // gets the first tombstone met, else the empty slot that ended the walk, else -1.
    function automatic int find_slot(logic [63:0] k, logic [63:0] m, output int free_slot);
        int idx;
        int tomb;
        idx = int'(fnv1a(k, hashed_bytes()) & 64'(SLOTS - 1));
        tomb = -1;
        free_slot = -1;
        for (int p = 0; p < SLOTS; p++) begin
            if (mirror_status[idx] == lph_pkg::SLOT_EMPTY) begin
                free_slot = (tomb >= 0) ? tomb : idx;
                return -1;
            end
            if (mirror_status[idx] == lph_pkg::SLOT_TOMB && tomb < 0) tomb = idx;
            if (mirror_status[idx] == lph_pkg::SLOT_USED && (mirror_key[idx] & m) == k)
                return idx;
            idx = (idx + 1) % SLOTS;
        end
        free_slot = tomb;
        return -1;
    endfunction

    // Applies one accepted command to the mirror and queues the reply it causes.
    task automatic apply_table_cmd(table_cmd_t c);
        table_reply_t r;
        logic [63:0]  m;
        logic [63:0]  k;
        int           hit;
        int           fr;
        m = bytes_mask(hashed_bytes());
        k = c.key & m;
        r.status = lph_pkg::RES_NONE;
        r.data = '0;
        r.key = '0;
        case (c.req)
            lph_pkg::REQ_INSERT: begin
                hit = find_slot(k, m, fr);
                if (hit >= 0) begin
                    r.data = mirror_value[hit];
                    mirror_value[hit] = c.value;
                    r.status = lph_pkg::RES_FOUND;
                end else if (mirror_count * 4 >= SLOTS * 3 || fr < 0) begin
                    r.status = lph_pkg::RES_FULL;
                end else begin
                    mirror_status[fr] = lph_pkg::SLOT_USED;
                    mirror_key[fr] = k;
                    mirror_value[fr] = c.value;
                    mirror_count++;
                end
            end
            lph_pkg::REQ_LOOKUP, lph_pkg::REQ_REMOVE: begin
                hit = find_slot(k, m, fr);
                if (hit >= 0) begin
                    r.data = mirror_value[hit];
                    r.status = lph_pkg::RES_FOUND;
                    if (c.req == lph_pkg::REQ_REMOVE) begin
                        mirror_status[hit] = lph_pkg::SLOT_TOMB;
                        mirror_count--;
                    end
                end
            end
            lph_pkg::REQ_REWIND: mirror_cursor = 0;
            lph_pkg::REQ_NEXT: begin
                while (mirror_cursor < SLOTS) begin
                    hit = mirror_cursor;
                    mirror_cursor++;
                    if (mirror_status[hit] == lph_pkg::SLOT_USED) begin
                        r.status = lph_pkg::RES_FOUND;
                        r.data = mirror_value[hit];
                        r.key = mirror_key[hit];
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.total = 9'(mirror_count);
        reply_queue.push_back(r);
    endtask

    task automatic queue_cmd(logic [2:0] rq, logic [63:0] k, logic [63:0] v);
        table_cmd_t c;
        c.req = rq;
        c.key = k;
        c.value = v;
        cmd_backlog.push_back(c);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Waits until every command is sent and every reply has come back.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || start || reply_queue.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Writes key_bytes while the block is idle.
    task automatic write_key_bytes(logic [3:0] kb);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= kb;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror_key_bytes = kb;
    endtask

    // One random phase: mostly inserts, lookups and removes on pooled keys, with scans,
    // fully random keys and the unused request codes mixed in.
    task automatic random_phase(int n);
        int          sel;
        logic [2:0]  rq;
        logic [63:0] k;
        for (int i = 0; i < 64; i++) key_pool[i] = rand64();
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) rq = lph_pkg::REQ_INSERT;
            else if (sel < 65) rq = lph_pkg::REQ_LOOKUP;
            else if (sel < 85) rq = lph_pkg::REQ_REMOVE;
            else if (sel < 88) rq = lph_pkg::REQ_REWIND;
            else if (sel < 97) rq = lph_pkg::REQ_NEXT;
            else rq = 3'($urandom_range(5, 7));
            k = ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(63)];
            queue_cmd(rq, k, rand64());
        end
        wait_drained();
    endtask

    // Driver: start stays high until the transaction is taken, then the next one follows.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) apply_table_cmd(cmd_on_bus);
            if (!start || !busy) begin
                if (cmd_backlog.size() != 0 && !(gaps_enabled && $urandom_range(99) < 24)) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    start <= 1'b1;
                    req_type <= cmd_on_bus.req;
                    key <= cmd_on_bus.key;
                    value <= cmd_on_bus.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done pulse is compared with the oldest queued reply.
    always @(posedge clk) begin
        table_reply_t want;
        if (rst_n && done) begin
            if (reply_queue.size() == 0) begin
                $display("%0t: unexpected result status %0d data %h", $time, status, data_out);
                error_count++;
            end else begin
                want = reply_queue.pop_front();
                if (status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    error_count++;
                end
                if (data_out !== want.data) begin
                    $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
                    error_count++;
                end
                if (key_out !== want.key) begin
                    $display("%0t: key_out expected %h actual %h", $time, want.key, key_out);
                    error_count++;
                end
                if (entry_total !== want.total) begin
                    $display("%0t: entry_total expected %0d actual %0d", $time, want.total,
                             entry_total);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("linear_probe_hash_table_core test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            mirror_status[i] = lph_pkg::SLOT_EMPTY;
            mirror_key[i] = '0;
            mirror_value[i] = '0;
        end
        mirror_count = 0;
        mirror_cursor = 0;
        mirror_key_bytes = 4'd8;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset width: extremes, update, absent keys, scan to the end
        // and the unused request codes.
        queue_cmd(lph_pkg::REQ_INSERT, '1, '1);
        queue_cmd(lph_pkg::REQ_INSERT, '0, '0);
        queue_cmd(lph_pkg::REQ_LOOKUP, '1, '0);
        queue_cmd(lph_pkg::REQ_INSERT, '1, 64'h0123_4567_89AB_CDEF);
        queue_cmd(lph_pkg::REQ_LOOKUP, 64'h5555_AAAA_5555_AAAA, '1);
        queue_cmd(lph_pkg::REQ_REMOVE, '0, '0);
        queue_cmd(lph_pkg::REQ_REMOVE, '0, '0);
        queue_cmd(lph_pkg::REQ_LOOKUP, '0, '0);
        queue_cmd(lph_pkg::REQ_INSERT, '0, 64'hAAAA_5555_AAAA_5555);
        queue_cmd(lph_pkg::REQ_REWIND, '0, '0);
        queue_cmd(lph_pkg::REQ_NEXT, '0, '0);
        queue_cmd(lph_pkg::REQ_NEXT, '0, '0);
        queue_cmd(lph_pkg::REQ_NEXT, '0, '0);
        queue_cmd(lph_pkg::REQ_NEXT, '1, '1);
        queue_cmd(3'd5, '1, '1);
        queue_cmd(3'd6, '0, '0);
        queue_cmd(3'd7, '1, '1);
        queue_cmd(lph_pkg::REQ_REWIND, '1, '1);
        queue_cmd(lph_pkg::REQ_NEXT, '0, '0);
        wait_drained();

        // One byte keys come first, so that tombstone reuse appears.
        write_key_bytes(4'd1);
        random_phase(220);
        gaps_enabled = 1'b0;
        write_key_bytes(4'd0);
        random_phase(130);
        gaps_enabled = 1'b1;
        write_key_bytes(4'd8);
        random_phase(150);
        write_key_bytes(4'd15);
        random_phase(120);
        write_key_bytes(4'd3);
        random_phase(130);
        write_key_bytes(4'd2);
        random_phase(100);

        repeat (20) @(posedge clk);
        if (error_count == 0) begin
            $display("linear_probe_hash_table_core test passed");
        end else begin
            $display("linear_probe_hash_table_core test failed");
        end
        $finish;
    end

endmodule
